// ===== hdl/expression_tokenizer_assert.svh =====
// Assertion macros for the expression tokenizer.
// Uses clk and rst_n of the including module; define NO_ASSERTIONS to drop them.
`ifndef EXPRESSION_TOKENIZER_ASSERT_SVH
`define EXPRESSION_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ET_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define ET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define ET_ASSERT_NOW(lbl, ante, cons)
`define ET_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/expt_pkg.sv =====
// Shared types, codes and character helpers for the expression tokenizer.
// No dependencies.
`timescale 1ns / 1ps
package expt_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_S,
    MODE_SU,
    MODE_SQ,
    MODE_SQR,
    MODE_E,
    MODE_EX
  } scan_mode_t;

  localparam logic [4:0] KIND_C       = 5'd14;
  localparam logic [4:0] KIND_A       = 5'd15;
  localparam logic [4:0] KIND_SUM     = 5'd16;
  localparam logic [4:0] KIND_EXP     = 5'd17;
  localparam logic [4:0] KIND_SQRT    = 5'd18;
  localparam logic [4:0] KIND_NUM     = 5'd19;
  localparam logic [4:0] KIND_ID      = 5'd20;
  localparam logic [4:0] KIND_END     = 5'd21;
  localparam logic [4:0] KIND_BAD     = 5'd22;
  localparam logic [4:0] KIND_RUNAWAY = 5'd23;

  localparam logic [7:0]  CH_NUL  = 8'h00;
  localparam logic [7:0]  CH_NL   = 8'h0A;
  localparam logic [7:0]  CH_HASH = "#";
  localparam logic [7:0]  CH_C    = "c";
  localparam logic [7:0]  CH_A    = "a";
  localparam logic [7:0]  CH_S    = "s";
  localparam logic [7:0]  CH_E    = "e";

  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
  localparam logic [7:0]  LEN_MAX  = 8'd255;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = 2;
  localparam int unsigned QLVL_BITS   = 3;

  typedef struct packed {
    logic [4:0]  kind;
    logic [23:0] line_no;
    logic [31:0] offset;
    logic [7:0]  length;
    logic        last;
  } token_t;

  // Up to two tokens caused by one byte, in emission order.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } lex_out_t;

  typedef struct packed {
    logic [QLVL_BITS-1:0] level;
    logic                 has_room;
    logic                 nonempty;
  } tokq_stat_t;

  // {hit, kind} for the fourteen single-character operators and brackets
  function automatic logic [5:0] op_lookup(input logic [7:0] b);
    logic [5:0] r;
    unique case (b)
      ",":     r = {1'b1, 5'd0};
      "-":     r = {1'b1, 5'd1};
      "+":     r = {1'b1, 5'd2};
      "/":     r = {1'b1, 5'd3};
      "*":     r = {1'b1, 5'd4};
      "^":     r = {1'b1, 5'd5};
      "!":     r = {1'b1, 5'd6};
      "=":     r = {1'b1, 5'd7};
      "(":     r = {1'b1, 5'd8};
      ")":     r = {1'b1, 5'd9};
      "[":     r = {1'b1, 5'd10};
      "]":     r = {1'b1, 5'd11};
      "{":     r = {1'b1, 5'd12};
      "}":     r = {1'b1, 5'd13};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

endpackage

// ===== hdl/expt_if.sv =====
// Valid/ready channel interfaces: text bytes in, tokens out.
// No dependencies.
`timescale 1ns / 1ps
interface expt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface expt_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [23:0] token_line;
  logic [31:0] token_offset;
  logic [7:0]  token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_line, output token_offset,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_line, input token_offset,
                input token_length, input last_of_run, output ready);
endinterface

// ===== hdl/expression_tokenizer.sv =====
// Expression tokenizer: takes one byte per beat, delivers tokens with kind,
// line, offset and length. A token is registered into the token queue with
// the byte that completes it and is offered on out_ch at the queue head.
// Throughput: one byte per cycle, but in_ch stalls while the four-entry
// token queue holds more than two tokens; out_ch gives one token per beat.
// Reset (synchronous, rst_n low) clears scanner state and empties the queue.
`timescale 1ns / 1ps
`include "expression_tokenizer_assert.svh"
module expression_tokenizer import expt_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input logic          clk,
  input logic          rst_n,
  expt_byte_if.sink    in_ch,
  expt_token_if.source out_ch
);

  lex_out_t   lex;
  tokq_stat_t q_stat;
  token_t     head;
  logic       in_fire, out_fire;
  token_t     last_tok;

  assign in_ch.ready = q_stat.has_room;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  expt_lexer #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_fire),
    .text_byte (in_ch.text_byte),
    .lex       (lex)
  );

  expt_tokq u_tokq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_fire),
    .lex   (lex),
    .pop   (out_fire),
    .head  (head),
    .stat  (q_stat)
  );

  assign out_ch.valid        = q_stat.nonempty;
  assign out_ch.token_kind   = head.kind;
  assign out_ch.token_line   = head.line_no;
  assign out_ch.token_offset = head.offset;
  assign out_ch.token_length = head.length;
  assign out_ch.last_of_run  = head.last;

  assign last_tok = (lex.count == 2'd2) ? lex.tok1 : lex.tok0;

  // end byte always closes the beat with an end token
  `ET_ASSERT_NOW(a_end_token, in_fire && (in_ch.text_byte == CH_NUL), (lex.count != 2'd0) && (last_tok.kind == KIND_END))
  `ET_ASSERT_NOW(a_no_overflow, in_fire, q_stat.level <= QLVL_BITS'(QUEUE_DEPTH - 2))
  `ET_ASSERT_NEXT(a_pop_only, out_fire && !in_fire, q_stat.level == $past(q_stat.level) - 3'd1)
  `ET_ASSERT_NOW(a_two_has_sb_last, in_fire && (lex.count == 2'd2), !lex.tok0.last && lex.tok1.last)

endmodule

// ===== hdl/expt_lexer.sv =====
// Scanner state machine: classifies one byte per beat, yields 0..2 tokens.
// Depends on expt_pkg.
`timescale 1ns / 1ps
module expt_lexer import expt_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] text_byte,
  output lex_out_t   lex
);

  scan_mode_t             mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] spos_r, spos_nxt;
  logic [23:0]            line_r, line_nxt;
  logic [23:0]            sline_r, sline_nxt;
  logic [7:0]             rlen_r, rlen_nxt;

  logic [63:0] pos_ext, spos_ext;
  logic [5:0]  op_res;
  logic [7:0]  grown;

  // start-of-token classification
  logic       sb_emit, sb_begin, sb_nl, sb_end;
  logic [4:0] sb_kind;
  logic [7:0] sb_len;
  scan_mode_t sb_mode;

  // keyword prefix matching
  logic       kw_match, kw_done;
  logic [4:0] kw_kind;
  scan_mode_t kw_next;

  logic       use_sb, run_emit, run_grow_len, grow, sb_fire;
  logic [4:0] run_kind;
  token_t     run_tok, sb_tok;

  assign pos_ext  = 64'(pos_r);
  assign spos_ext = 64'(spos_r);
  assign op_res   = op_lookup(text_byte);
  assign grown    = (rlen_r == LEN_MAX) ? rlen_r : rlen_r + 8'd1;

  always_comb begin
    sb_emit  = 1'b0;
    sb_begin = 1'b0;
    sb_nl    = 1'b0;
    sb_end   = 1'b0;
    sb_kind  = KIND_BAD;
    sb_len   = 8'd1;
    sb_mode  = MODE_IDLE;
    priority if (text_byte == CH_NUL) begin
      sb_emit = 1'b1;
      sb_kind = KIND_END;
      sb_len  = 8'd0;
      sb_end  = 1'b1;
    end else if (is_space(text_byte)) begin
      sb_nl = (text_byte == CH_NL);
    end else if (text_byte == CH_HASH) begin
      sb_begin = 1'b1;
      sb_mode  = MODE_COMMENT;
    end else if (op_res[5]) begin
      sb_emit = 1'b1;
      sb_kind = op_res[4:0];
    end else if (text_byte == CH_C) begin
      sb_emit = 1'b1;
      sb_kind = KIND_C;
    end else if (text_byte == CH_A) begin
      sb_emit = 1'b1;
      sb_kind = KIND_A;
    end else if (text_byte == CH_S) begin
      sb_begin = 1'b1;
      sb_mode  = MODE_S;
    end else if (text_byte == CH_E) begin
      sb_begin = 1'b1;
      sb_mode  = MODE_E;
    end else if (is_digit(text_byte)) begin
      sb_begin = 1'b1;
      sb_mode  = MODE_NUMBER;
    end else if (is_alpha(text_byte)) begin
      sb_begin = 1'b1;
      sb_mode  = MODE_IDENT;
    end else begin
      sb_emit = 1'b1;
    end
  end

  always_comb begin
    kw_match = 1'b0;
    kw_done  = 1'b0;
    kw_kind  = KIND_SUM;
    kw_next  = MODE_IDLE;
    unique case (mode_r)
      MODE_S: begin
        kw_match = (text_byte == "q") || (text_byte == "u");
        kw_next  = (text_byte == "q") ? MODE_SQ : MODE_SU;
      end
      MODE_SU: begin
        kw_match = (text_byte == "m");
        kw_done  = 1'b1;
        kw_kind  = KIND_SUM;
      end
      MODE_SQ: begin
        kw_match = (text_byte == "r");
        kw_next  = MODE_SQR;
      end
      MODE_SQR: begin
        kw_match = (text_byte == "t");
        kw_done  = 1'b1;
        kw_kind  = KIND_SQRT;
      end
      MODE_E: begin
        kw_match = (text_byte == "x");
        kw_next  = MODE_EX;
      end
      MODE_EX: begin
        kw_match = (text_byte == "p");
        kw_done  = 1'b1;
        kw_kind  = KIND_EXP;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    use_sb       = 1'b0;
    run_emit     = 1'b0;
    run_grow_len = 1'b0;
    grow         = 1'b0;
    run_kind     = KIND_ID;
    mode_nxt     = mode_r;
    unique case (mode_r)
      MODE_COMMENT: begin
        if (text_byte == CH_NUL) begin
          run_emit = 1'b1;
          run_kind = KIND_RUNAWAY;
          use_sb   = 1'b1;
        end else if (text_byte == CH_NL) begin
          use_sb = 1'b1;
        end else begin
          grow = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(text_byte)) begin
          grow = 1'b1;
        end else begin
          run_emit = 1'b1;
          run_kind = KIND_NUM;
          use_sb   = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_alpha(text_byte)) begin
          grow = 1'b1;
        end else begin
          run_emit = 1'b1;
          use_sb   = 1'b1;
        end
      end
      MODE_S, MODE_SU, MODE_SQ, MODE_SQR, MODE_E, MODE_EX: begin
        if (kw_match) begin
          grow = 1'b1;
          if (kw_done) begin
            run_emit     = 1'b1;
            run_kind     = kw_kind;
            run_grow_len = 1'b1;
            mode_nxt     = MODE_IDLE;
          end else begin
            mode_nxt = kw_next;
          end
        end else if (is_alpha(text_byte)) begin
          // broken prefix continues as an identifier
          grow     = 1'b1;
          mode_nxt = MODE_IDENT;
        end else begin
          run_emit = 1'b1;
          use_sb   = 1'b1;
        end
      end
      default: begin
        use_sb = 1'b1;
      end
    endcase
    if (use_sb) begin
      mode_nxt = sb_mode;
    end
  end

  assign sb_fire = use_sb && sb_emit;

  always_comb begin
    run_tok.kind    = run_kind;
    run_tok.line_no = sline_r;
    run_tok.offset  = spos_ext[31:0];
    run_tok.length  = run_grow_len ? grown : rlen_r;
    run_tok.last    = !sb_fire;

    sb_tok.kind    = sb_kind;
    sb_tok.line_no = line_r;
    sb_tok.offset  = pos_ext[31:0];
    sb_tok.length  = sb_len;
    sb_tok.last    = 1'b1;

    lex.count = {1'b0, run_emit} + {1'b0, sb_fire};
    lex.tok0  = run_emit ? run_tok : sb_tok;
    lex.tok1  = sb_tok;
  end

  always_comb begin
    spos_nxt  = spos_r;
    sline_nxt = sline_r;
    rlen_nxt  = rlen_r;
    if (use_sb && sb_begin) begin
      spos_nxt  = pos_r;
      sline_nxt = line_r;
      rlen_nxt  = 8'd1;
    end else if (grow) begin
      rlen_nxt = grown;
    end

    line_nxt = line_r;
    if (use_sb && sb_end) begin
      line_nxt = 24'd1;
    end else if (use_sb && sb_nl && (line_r != LINE_MAX)) begin
      line_nxt = line_r + 24'd1;
    end

    // restart counting for the next text after the end byte
    pos_nxt = (use_sb && sb_end) ? '0 : pos_r + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      spos_r  <= '0;
      line_r  <= 24'd1;
      sline_r <= 24'd1;
      rlen_r  <= 8'd0;
    end else if (take) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      spos_r  <= spos_nxt;
      line_r  <= line_nxt;
      sline_r <= sline_nxt;
      rlen_r  <= rlen_nxt;
    end
  end

endmodule

// ===== hdl/expt_tokq.sv =====
// Four-entry token queue: takes up to two tokens per beat, gives one.
// Depends on expt_pkg.
`timescale 1ns / 1ps
module expt_tokq import expt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lex_out_t   lex,
  input  logic       pop,
  output token_t     head,
  output tokq_stat_t stat
);

  token_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QLVL_BITS-1:0] level_r, level_nxt;
  logic [1:0]           push_n;

  assign push_n    = push ? lex.count : 2'd0;
  assign wr_nxt    = wr_r + QPTR_BITS'(push_n);
  assign rd_nxt    = rd_r + QPTR_BITS'(pop);
  assign level_nxt = level_r + QLVL_BITS'(push_n) - QLVL_BITS'(pop);

  assign head          = slot_r[rd_r];
  assign stat.level    = level_r;
  assign stat.nonempty = (level_r != '0);
  // keep room for the two tokens one byte may cause
  assign stat.has_room = (level_r <= QLVL_BITS'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      slot_r[wr_r] <= lex.tok0;
    end
    if (push_n == 2'd2) begin
      slot_r[wr_r + QPTR_BITS'(1)] <= lex.tok1;
    end
  end

endmodule

// ===== tb/sv/tb_expression_tokenizer.sv =====
// Self-checking testbench for expression_tokenizer: drives text bytes on in_ch,
// predicts every token from its own lexer state and checks each beat on out_ch.
// Depends on expt_pkg, the expt_byte_if and expt_token_if interfaces and the RTL.
`timescale 1ns / 1ps
module tb_expression_tokenizer;
  import expt_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 8;

  // Operator and bracket characters; the index is the token kind.
  localparam logic [8*14-1:0] OP_CHARS = ",-+/*^!=()[]{}";

  localparam logic [7:0] CH_U = "u";
  localparam logic [7:0] CH_M = "m";
  localparam logic [7:0] CH_Q = "q";
  localparam logic [7:0] CH_R = "r";
  localparam logic [7:0] CH_T = "t";
  localparam logic [7:0] CH_X = "x";
  localparam logic [7:0] CH_P = "p";

  string KW_TEXT [3] = '{"sum", "exp", "sqrt"};

  logic clk;
  logic rst_n;

  expt_byte_if  in_ch();
  expt_token_if out_ch();

  expression_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Lexer state mirrored by the predictor.
  scan_mode_t  lex_mode;
  logic [31:0] lex_pos;
  logic [23:0] lex_line;
  logic [31:0] run_start_pos;
  logic [23:0] run_start_line;
  logic [7:0]  run_len;
  bit          text_done;

  token_t byte_tokens[$];
  token_t expected_tokens[$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  bit  sender_steady = 1'b0;
  bit  hold_req = 1'b0;

  function automatic int op_index(input logic [7:0] b);
    for (int i = 0; i < 14; i++) begin
      if (OP_CHARS[8 * (13 - i) +: 8] == b) return i;
    end
    return -1;
  endfunction

  function automatic bit digit_byte(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit letter_byte(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit blank_byte(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic void note_token(input logic [4:0] kind, input logic [23:0] tk_line,
                                     input logic [31:0] tk_off, input logic [7:0] tk_len);
    token_t t;
    t.kind    = kind;
    t.line_no = tk_line;
    t.offset  = tk_off;
    t.length  = tk_len;
    t.last    = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic void open_run(input scan_mode_t m);
    lex_mode       = m;
    run_start_pos  = lex_pos;
    run_start_line = lex_line;
    run_len        = 8'd1;
  endfunction

  function automatic void extend_run();
    if (run_len != LEN_MAX) run_len++;
  endfunction

  function automatic void close_run(input logic [4:0] kind);
    note_token(kind, run_start_line, run_start_pos, run_len);
    lex_mode = MODE_IDLE;
  endfunction

  // Handle a byte that arrives between tokens.
  function automatic void scan_fresh(input logic [7:0] b);
    int k;
    lex_mode = MODE_IDLE;
    k = op_index(b);
    if (b == CH_NUL) begin
      note_token(KIND_END, lex_line, lex_pos, 8'd0);
      text_done = 1'b1;
    end else if (blank_byte(b)) begin
      if (b == CH_NL && lex_line != LINE_MAX) lex_line++;
    end else if (b == CH_HASH) begin
      open_run(MODE_COMMENT);
    end else if (k >= 0) begin
      note_token(k[4:0], lex_line, lex_pos, 8'd1);
    end else if (b == CH_C) begin
      note_token(KIND_C, lex_line, lex_pos, 8'd1);
    end else if (b == CH_A) begin
      note_token(KIND_A, lex_line, lex_pos, 8'd1);
    end else if (b == CH_S) begin
      open_run(MODE_S);
    end else if (b == CH_E) begin
      open_run(MODE_E);
    end else if (digit_byte(b)) begin
      open_run(MODE_NUMBER);
    end else if (letter_byte(b)) begin
      open_run(MODE_IDENT);
    end else begin
      note_token(KIND_BAD, lex_line, lex_pos, 8'd1);
    end
  endfunction

  function automatic void reset_lexer();
    lex_mode       = MODE_IDLE;
    lex_pos        = '0;
    lex_line       = 24'd1;
    run_start_pos  = '0;
    run_start_line = 24'd1;
    run_len        = '0;
    text_done      = 1'b0;
  endfunction

  // Advance the lexer by one accepted byte and queue the tokens it completes.
  function automatic void predict_tokens(input logic [7:0] b);
    logic [7:0] want;
    scan_mode_t next_mode;
    logic [4:0] kw_kind;
    bit         kw_done;
    text_done = 1'b0;
    byte_tokens.delete();
    want      = CH_NUL;
    next_mode = MODE_IDLE;
    kw_kind   = KIND_ID;
    kw_done   = 1'b0;
    case (lex_mode)
      MODE_IDLE: scan_fresh(b);
      MODE_COMMENT: begin
        if (b == CH_NUL) begin
          note_token(KIND_RUNAWAY, run_start_line, run_start_pos, run_len);
          scan_fresh(b);
        end else if (b == CH_NL) begin
          scan_fresh(b);
        end else begin
          extend_run();
        end
      end
      MODE_NUMBER: begin
        if (digit_byte(b)) begin
          extend_run();
        end else begin
          close_run(KIND_NUM);
          scan_fresh(b);
        end
      end
      MODE_IDENT: begin
        if (letter_byte(b)) begin
          extend_run();
        end else begin
          close_run(KIND_ID);
          scan_fresh(b);
        end
      end
      default: begin
        case (lex_mode)
          MODE_S: begin
            if (b == CH_Q) begin
              want = CH_Q;
              next_mode = MODE_SQ;
            end else begin
              want = CH_U;
              next_mode = MODE_SU;
            end
          end
          MODE_SU: begin
            want = CH_M;
            kw_kind = KIND_SUM;
            kw_done = 1'b1;
          end
          MODE_SQ: begin
            want = CH_R;
            next_mode = MODE_SQR;
          end
          MODE_SQR: begin
            want = CH_T;
            kw_kind = KIND_SQRT;
            kw_done = 1'b1;
          end
          MODE_E: begin
            want = CH_X;
            next_mode = MODE_EX;
          end
          default: begin
            want = CH_P;
            kw_kind = KIND_EXP;
            kw_done = 1'b1;
          end
        endcase
        if (b == want) begin
          extend_run();
          if (kw_done) close_run(kw_kind);
          else lex_mode = next_mode;
        end else if (letter_byte(b)) begin
          // broken prefix carries on as an identifier
          extend_run();
          lex_mode = MODE_IDENT;
        end else begin
          close_run(KIND_ID);
          scan_fresh(b);
        end
      end
    endcase
    if (text_done) begin
      lex_pos  = '0;
      lex_line = 24'd1;
    end else begin
      lex_pos++;
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && !sender_steady && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predict_tokens(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] random_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "a" : "A";
    return 8'(base + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] comment_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_NL);
    return b;
  endfunction

  task automatic send_fragment();
    string      word;
    logic [7:0] b;
    int         k;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: send_byte(OP_CHARS[8 * $urandom_range(0, 13) +: 8]);
      4: send_byte($urandom_range(0, 1) ? CH_C : CH_A);
      5, 6: send_text(KW_TEXT[$urandom_range(0, 2)]);
      7, 8: begin
        word = KW_TEXT[$urandom_range(0, 2)];
        send_text(word.substr(0, $urandom_range(0, word.len() - 2)));
        case ($urandom_range(0, 4))
          0: send_byte(random_letter());
          1: send_byte(8'("0" + $urandom_range(0, 9)));
          2: send_byte(OP_CHARS[8 * $urandom_range(0, 13) +: 8]);
          3: send_byte(" ");
          default: send_byte(CH_NUL);
        endcase
      end
      9, 10: repeat ($urandom_range(1, 6)) send_byte(8'("0" + $urandom_range(0, 9)));
      11, 12: repeat ($urandom_range(1, 6)) send_byte(random_letter());
      13, 14: begin
        repeat ($urandom_range(1, 3)) begin
          k = $urandom_range(0, 5);
          send_byte(k == 0 ? " " : 8'(8 + k));
        end
      end
      15: begin
        send_byte(CH_HASH);
        repeat ($urandom_range(0, 8)) send_byte(comment_char());
        send_byte($urandom_range(0, 4) == 0 ? CH_NUL : CH_NL);
      end
      16: begin
        do b = 8'($urandom_range(1, 255));
        while (op_index(b) >= 0 || digit_byte(b) || letter_byte(b) || blank_byte(b) ||
               b == CH_HASH);
        send_byte(b);
      end
      17: send_byte(CH_NUL);
      default: send_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic wait_tokens_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_tokens.size() != 0);
  endtask

  task automatic test_directed();
    send_text(",-+/*^!=()[]{}");
    send_text("casumexpsqrt");
    send_byte(8'hFF);
    // comment cut off by end of text
    send_text("#x");
    send_byte(CH_NUL);
  endtask

  // A digit run long enough to pin the length at its ceiling.
  task automatic test_long_runs();
    send_byte("1");
    repeat (257) send_byte(8'("0" + $urandom_range(0, 9)));
    send_byte(" ");
  endtask

  task automatic test_random(input int n);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < n) send_fragment();
  endtask

  // Stall the token side while bytes keep coming so the queue fills.
  task automatic test_backpressure();
    sender_steady = 1'b1;
    hold_req = 1'b1;
    repeat (30) send_fragment();
    sender_steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat ($urandom_range(4, 12)) send_fragment();
      wait_tokens_drained();
    end
  endtask

  initial begin : sink_ready
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_tokens
    token_t want_tok;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_tokens.size() == 0) begin
        $error("token with no prediction: kind %0d offset %0d",
               out_ch.token_kind, out_ch.token_offset);
        errors++;
      end else begin
        want_tok = expected_tokens.pop_front();
        if (out_ch.token_kind !== want_tok.kind) begin
          $error("token_kind: expected %0d, got %0d", want_tok.kind, out_ch.token_kind);
          errors++;
        end
        if (out_ch.token_line !== want_tok.line_no) begin
          $error("token_line: expected %0d, got %0d", want_tok.line_no, out_ch.token_line);
          errors++;
        end
        if (out_ch.token_offset !== want_tok.offset) begin
          $error("token_offset: expected %0d, got %0d", want_tok.offset, out_ch.token_offset);
          errors++;
        end
        if (out_ch.token_length !== want_tok.length) begin
          $error("token_length: expected %0d, got %0d", want_tok.length, out_ch.token_length);
          errors++;
        end
        if (out_ch.last_of_run !== want_tok.last) begin
          $error("last_of_run: expected %0d, got %0d", want_tok.last, out_ch.last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.text_byte = 8'd0;
    reset_lexer();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_long_runs();
    test_random(80);
    test_backpressure();
    test_drain_pause();
    test_random(30);
    calm = 1'b1;
    test_random(30);
    // flush any open run
    send_byte(CH_NUL);
    wait_tokens_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
